@@ hdl/qte_pkg.sv @@
// Shared types, constants and the arctangent table for the quaternion to Euler converter.
// No dependencies.
package qte_pkg;

   localparam int QUAT_WIDTH    = 16;
   localparam int PROD_WIDTH    = 32;
   localparam int OPND_WIDTH    = 34;
   localparam int RAD_WIDTH     = 64;
   localparam int ROOT_WIDTH    = 32;
   localparam int REM_WIDTH     = 34;
   localparam int PRESHIFT      = 20;
   localparam int CORDIC_WIDTH  = 58;
   localparam int ANGLE_WIDTH   = 34;
   localparam int OUT_WIDTH     = 16;
   localparam int ATAN_WIDTH    = 31;

   localparam logic [ANGLE_WIDTH-1:0] HALF_PI_Q30 = 34'd1686629713;
   localparam logic [29:0]            DEG64_Q18   = 30'd961263669;

   typedef logic signed [OPND_WIDTH-1:0] opnd_type;

   // atan2 operand pairs that travel alongside the square root
   typedef struct packed {
      opnd_type yaw_y;
      opnd_type yaw_x;
      opnd_type roll_y;
      opnd_type roll_x;
      opnd_type pitch_y;
   } qte_ops_type;

   // atan(2^-idx) in Q30, rounded half up
   function automatic logic [ATAN_WIDTH-1:0] atan_q30(input int unsigned idx);
      logic [ATAN_WIDTH-1:0] a;
      case (idx)
         0:  a = 31'd843314857;
         1:  a = 31'd497837829;
         2:  a = 31'd263043837;
         3:  a = 31'd133525159;
         4:  a = 31'd67021687;
         5:  a = 31'd33543516;
         6:  a = 31'd16775851;
         7:  a = 31'd8388437;
         8:  a = 31'd4194283;
         9:  a = 31'd2097149;
         10: a = 31'd1048576;
         11: a = 31'd524288;
         12: a = 31'd262144;
         13: a = 31'd131072;
         14: a = 31'd65536;
         15: a = 31'd32768;
         16: a = 31'd16384;
         17: a = 31'd8192;
         18: a = 31'd4096;
         19: a = 31'd2048;
         20: a = 31'd1024;
         21: a = 31'd512;
         22: a = 31'd256;
         23: a = 31'd128;
         24: a = 31'd64;
         25: a = 31'd32;
         26: a = 31'd16;
         27: a = 31'd8;
         28: a = 31'd4;
         29: a = 31'd2;
         30: a = 31'd1;
         31: a = 31'd1;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

@@ hdl/qte_front.sv @@
// Front end: products, atan2 operand sums, pitch scaling and the squared radicand.
// Five register stages. Depends on qte_pkg.
module qte_front import qte_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  logic signed [QUAT_WIDTH-1:0] quat_real,
   input  logic signed [QUAT_WIDTH-1:0] quat_i,
   input  logic signed [QUAT_WIDTH-1:0] quat_j,
   input  logic signed [QUAT_WIDTH-1:0] quat_k,
   output logic                         out_valid,
   output logic [RAD_WIDTH-1:0]         out_rad,
   output qte_ops_type                  out_ops
);

   localparam logic signed [OPND_WIDTH-1:0] LIM = 34'sd2147483648;

   logic [4:0] vld_ff;

   // stage 1: products
   logic signed [PROD_WIDTH-1:0] sr_ff, si_ff, sj_ff, sk_ff;
   logic signed [PROD_WIDTH-1:0] pij_ff, pkr_ff, pjk_ff, pir_ff, pjr_ff, pik_ff;
   // stage 2: sums
   qte_ops_type ops2_ff, ops2_in;
   // stage 3: scaled magnitudes
   qte_ops_type ops3_ff, ops3_in;
   logic [ROOT_WIDTH-1:0] ma_ff, mb_ff, ma_in, mb_in;
   // stage 4: squares
   qte_ops_type ops4_ff;
   logic [RAD_WIDTH-1:0] sqa_ff, sqb_ff;
   // stage 5: radicand
   qte_ops_type ops5_ff;
   logic [RAD_WIDTH-1:0] rad_ff;

   opnd_type num_s, a_s, b_s;
   logic     big;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sr_ff  <= PROD_WIDTH'(quat_real) * PROD_WIDTH'(quat_real);
         si_ff  <= PROD_WIDTH'(quat_i) * PROD_WIDTH'(quat_i);
         sj_ff  <= PROD_WIDTH'(quat_j) * PROD_WIDTH'(quat_j);
         sk_ff  <= PROD_WIDTH'(quat_k) * PROD_WIDTH'(quat_k);
         pij_ff <= PROD_WIDTH'(quat_i) * PROD_WIDTH'(quat_j);
         pkr_ff <= PROD_WIDTH'(quat_k) * PROD_WIDTH'(quat_real);
         pjk_ff <= PROD_WIDTH'(quat_j) * PROD_WIDTH'(quat_k);
         pir_ff <= PROD_WIDTH'(quat_i) * PROD_WIDTH'(quat_real);
         pjr_ff <= PROD_WIDTH'(quat_j) * PROD_WIDTH'(quat_real);
         pik_ff <= PROD_WIDTH'(quat_i) * PROD_WIDTH'(quat_k);
         ops2_ff <= ops2_in;
         ops3_ff <= ops3_in;
         ma_ff   <= ma_in;
         mb_ff   <= mb_in;
         ops4_ff <= ops3_ff;
         sqa_ff  <= RAD_WIDTH'(ma_ff) * RAD_WIDTH'(ma_ff);
         sqb_ff  <= RAD_WIDTH'(mb_ff) * RAD_WIDTH'(mb_ff);
         ops5_ff <= ops4_ff;
         rad_ff  <= sqa_ff + sqb_ff;
      end
   end

   always_comb begin
      ops2_in.yaw_y   = (OPND_WIDTH'(pij_ff) + OPND_WIDTH'(pkr_ff)) <<< 1;
      ops2_in.yaw_x   = OPND_WIDTH'(si_ff) - OPND_WIDTH'(sj_ff) - OPND_WIDTH'(sk_ff)
                        + OPND_WIDTH'(sr_ff);
      ops2_in.roll_y  = (OPND_WIDTH'(pjk_ff) + OPND_WIDTH'(pir_ff)) <<< 1;
      ops2_in.roll_x  = OPND_WIDTH'(sk_ff) + OPND_WIDTH'(sr_ff) - OPND_WIDTH'(si_ff)
                        - OPND_WIDTH'(sj_ff);
      ops2_in.pitch_y = (OPND_WIDTH'(pjr_ff) - OPND_WIDTH'(pik_ff)) <<< 1;
   end

   // halve all three pitch operands if any reaches 2^31, so the squares fit
   always_comb begin
      big = (ops2_ff.yaw_x >= LIM) || (ops2_ff.yaw_x <= -LIM) ||
            (ops2_ff.yaw_y >= LIM) || (ops2_ff.yaw_y <= -LIM) ||
            (ops2_ff.pitch_y >= LIM) || (ops2_ff.pitch_y <= -LIM);
      a_s   = big ? (ops2_ff.yaw_x >>> 1) : ops2_ff.yaw_x;
      b_s   = big ? (ops2_ff.yaw_y >>> 1) : ops2_ff.yaw_y;
      num_s = big ? (ops2_ff.pitch_y >>> 1) : ops2_ff.pitch_y;
      ma_in = a_s[OPND_WIDTH-1] ? ROOT_WIDTH'(-a_s) : ROOT_WIDTH'(a_s);
      mb_in = b_s[OPND_WIDTH-1] ? ROOT_WIDTH'(-b_s) : ROOT_WIDTH'(b_s);
      ops3_in = ops2_ff;
      ops3_in.pitch_y = num_s;
   end

   assign out_valid = vld_ff[4];
   assign out_rad   = rad_ff;
   assign out_ops   = ops5_ff;

endmodule

@@ hdl/qte_isqrt.sv @@
// Pipelined floor square root, one result bit per stage, carrying the atan2 operands.
// Depends on qte_pkg.
module qte_isqrt import qte_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic [RAD_WIDTH-1:0]  in_rad,
   input  qte_ops_type           in_ops,
   output logic                  out_valid,
   output logic [ROOT_WIDTH-1:0] out_root,
   output qte_ops_type           out_ops
);

   logic                  vld_w  [0:ROOT_WIDTH];
   logic [RAD_WIDTH-1:0]  rad_w  [0:ROOT_WIDTH];
   logic [REM_WIDTH-1:0]  rem_w  [0:ROOT_WIDTH];
   logic [ROOT_WIDTH-1:0] root_w [0:ROOT_WIDTH];
   qte_ops_type           ops_w  [0:ROOT_WIDTH];

   assign vld_w[0]  = in_valid;
   assign rad_w[0]  = in_rad;
   assign rem_w[0]  = '0;
   assign root_w[0] = '0;
   assign ops_w[0]  = in_ops;

   for (genvar k = 0; k < ROOT_WIDTH; k++) begin : g_step
      logic                  vld_ff;
      logic [RAD_WIDTH-1:0]  rad_ff;
      logic [REM_WIDTH-1:0]  rem_ff, rem_in;
      logic [ROOT_WIDTH-1:0] root_ff, root_in;
      qte_ops_type           ops_ff;
      logic [REM_WIDTH+1:0]  rem_sh, trial;

      always_comb begin
         rem_sh = {rem_w[k], rad_w[k][RAD_WIDTH-1 -: 2]};
         trial  = {2'b00, root_w[k], 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = REM_WIDTH'(rem_sh - trial);
            root_in = {root_w[k][ROOT_WIDTH-2:0], 1'b1};
         end else begin
            rem_in  = REM_WIDTH'(rem_sh);
            root_in = {root_w[k][ROOT_WIDTH-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (adv) begin
            vld_ff <= vld_w[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rad_ff  <= rad_w[k] << 2;
            rem_ff  <= rem_in;
            root_ff <= root_in;
            ops_ff  <= ops_w[k];
         end
      end

      assign vld_w[k+1]  = vld_ff;
      assign rad_w[k+1]  = rad_ff;
      assign rem_w[k+1]  = rem_ff;
      assign root_w[k+1] = root_ff;
      assign ops_w[k+1]  = ops_ff;
   end

   assign out_valid = vld_w[ROOT_WIDTH];
   assign out_root  = root_w[ROOT_WIDTH];
   assign out_ops   = ops_w[ROOT_WIDTH];

endmodule

@@ hdl/qte_cordic.sv @@
// Vectoring CORDIC atan2: one quadrant pre-rotation stage, then one stage per iteration.
// Angle in Q30 radians. Depends on qte_pkg.
module qte_cordic import qte_pkg::*; #(
   parameter int ITERATIONS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  opnd_type                      in_y,
   input  opnd_type                      in_x,
   output logic                          out_valid,
   output logic signed [ANGLE_WIDTH-1:0] out_angle
);

   logic                           vld_w  [0:ITERATIONS];
   logic                           zero_w [0:ITERATIONS];
   logic signed [CORDIC_WIDTH-1:0] x_w    [0:ITERATIONS];
   logic signed [CORDIC_WIDTH-1:0] y_w    [0:ITERATIONS];
   logic signed [ANGLE_WIDTH-1:0]  z_w    [0:ITERATIONS];

   logic                           vld0_ff, zero0_ff;
   logic signed [CORDIC_WIDTH-1:0] x0_ff, y0_ff, x0_in, y0_in, xs, ys;
   logic signed [ANGLE_WIDTH-1:0]  z0_ff, z0_in;

   always_comb begin
      xs = {CORDIC_WIDTH'(in_x)} <<< PRESHIFT;
      ys = {CORDIC_WIDTH'(in_y)} <<< PRESHIFT;
      x0_in = xs;
      y0_in = ys;
      z0_in = '0;
      // rotate left half-plane vectors by a quarter turn
      if (xs[CORDIC_WIDTH-1]) begin
         if (!ys[CORDIC_WIDTH-1]) begin
            x0_in = ys;
            y0_in = -xs;
            z0_in = $signed(HALF_PI_Q30);
         end else begin
            x0_in = -ys;
            y0_in = xs;
            z0_in = -$signed(HALF_PI_Q30);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
      end else if (adv) begin
         vld0_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zero0_ff <= (in_x == '0) && (in_y == '0);
         x0_ff    <= x0_in;
         y0_ff    <= y0_in;
         z0_ff    <= z0_in;
      end
   end

   assign vld_w[0]  = vld0_ff;
   assign zero_w[0] = zero0_ff;
   assign x_w[0]    = x0_ff;
   assign y_w[0]    = y0_ff;
   assign z_w[0]    = z0_ff;

   for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
      localparam logic signed [ANGLE_WIDTH-1:0] ATAN =
         $signed({{(ANGLE_WIDTH-ATAN_WIDTH){1'b0}}, atan_q30(i)});
      logic                           vld_ff, zero_ff;
      logic signed [CORDIC_WIDTH-1:0] x_ff, y_ff, x_in, y_in;
      logic signed [ANGLE_WIDTH-1:0]  z_ff, z_in;

      always_comb begin
         if (!y_w[i][CORDIC_WIDTH-1]) begin
            x_in = x_w[i] + (y_w[i] >>> i);
            y_in = y_w[i] - (x_w[i] >>> i);
            z_in = z_w[i] + ATAN;
         end else begin
            x_in = x_w[i] - (y_w[i] >>> i);
            y_in = y_w[i] + (x_w[i] >>> i);
            z_in = z_w[i] - ATAN;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (adv) begin
            vld_ff <= vld_w[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            zero_ff <= zero_w[i];
            x_ff    <= x_in;
            y_ff    <= y_in;
            z_ff    <= z_in;
         end
      end

      assign vld_w[i+1]  = vld_ff;
      assign zero_w[i+1] = zero_ff;
      assign x_w[i+1]    = x_ff;
      assign y_w[i+1]    = y_ff;
      assign z_w[i+1]    = z_ff;
   end

   // a zero vector has angle zero
   assign out_valid = vld_w[ITERATIONS];
   assign out_angle = zero_w[ITERATIONS] ? '0 : z_w[ITERATIONS];

endmodule

@@ hdl/qte_scale.sv @@
// Converts a Q30 radian angle to Q3.13 radians or 1/64 degree units, saturated to 16 bits.
// Two register stages. Depends on qte_pkg.
module qte_scale import qte_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          degrees_mode,
   input  logic                          in_valid,
   input  logic signed [ANGLE_WIDTH-1:0] in_angle,
   output logic                          out_valid,
   output logic signed [OUT_WIDTH-1:0]   out_angle
);

   localparam int LO_BITS  = 17;
   localparam int HI_BITS  = ANGLE_WIDTH - LO_BITS;
   localparam int PRD_BITS = 48;
   localparam int SUM_BITS = 66;
   localparam int VAL_BITS = 18;

   logic [1:0]                    vld_ff;
   logic [PRD_BITS-2:0]           plo_ff;
   logic signed [PRD_BITS-1:0]    phi_ff;
   logic signed [VAL_BITS-1:0]    radv_ff;
   logic signed [OUT_WIDTH-1:0]   ang_ff, ang_in;
   logic signed [ANGLE_WIDTH:0]   rad_sum;
   logic signed [SUM_BITS-1:0]    deg_sum;
   logic signed [VAL_BITS-1:0]    deg_v, sel_v;

   assign rad_sum = (ANGLE_WIDTH+1)'(in_angle) + (ANGLE_WIDTH+1)'(65536);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[0], in_valid};
      end
   end

   // split the angle so each multiply stays near 17 x 30 bits
   always_ff @(posedge clock) begin
      if (adv) begin
         plo_ff  <= (PRD_BITS-1)'(in_angle[LO_BITS-1:0]) * (PRD_BITS-1)'(DEG64_Q18);
         phi_ff  <= PRD_BITS'($signed(in_angle[ANGLE_WIDTH-1 -: HI_BITS]))
                    * $signed(PRD_BITS'(DEG64_Q18));
         radv_ff <= rad_sum[ANGLE_WIDTH -: VAL_BITS];
         ang_ff  <= ang_in;
      end
   end

   always_comb begin
      deg_sum = (SUM_BITS'(phi_ff) <<< LO_BITS) + $signed(SUM_BITS'(plo_ff))
                + (SUM_BITS'(1) <<< 47);
      deg_v   = deg_sum[SUM_BITS-1 -: VAL_BITS];
      sel_v   = degrees_mode ? deg_v : radv_ff;
      if (sel_v > VAL_BITS'(32767)) begin
         ang_in = 16'sh7FFF;
      end else if (sel_v < -VAL_BITS'(32768)) begin
         ang_in = -16'sh8000;
      end else begin
         ang_in = sel_v[OUT_WIDTH-1:0];
      end
   end

   assign out_valid = vld_ff[1];
   assign out_angle = ang_ff;

endmodule

@@ hdl/quaternion_to_euler_angles.sv @@
// Quaternion to Z-Y-X Euler angles (yaw, pitch, roll) converter, top level.
// Depends on qte_pkg, qte_front, qte_isqrt, qte_cordic, qte_scale.
//
//   port group | dir | handshake            | beat
//   req_*      | in  | req_valid/req_stall  | quat_real, quat_i, quat_j, quat_k
//   rsp_*      | out | rsp_valid/rsp_stall  | yaw_angle, pitch_angle, roll_angle
//   csr_*      | in  | csr_valid/csr_ready  | degrees_mode
//
// One beat accepted per cycle while req_stall is low. The pipeline runs front products
// and radicand, one square root bit per stage, one CORDIC iteration per stage, unit
// scaling and an output register, in that order.
// A skid register behind the output absorbs one beat; req_stall rises only when it fills.
// Synchronous reset clears valid bits and sets degrees mode.
module quaternion_to_euler_angles import qte_pkg::*; #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [QUAT_WIDTH-1:0] req_quat_real,
   input  logic signed [QUAT_WIDTH-1:0] req_quat_i,
   input  logic signed [QUAT_WIDTH-1:0] req_quat_j,
   input  logic signed [QUAT_WIDTH-1:0] req_quat_k,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [OUT_WIDTH-1:0]  rsp_yaw_angle,
   output logic signed [OUT_WIDTH-1:0]  rsp_pitch_angle,
   output logic signed [OUT_WIDTH-1:0]  rsp_roll_angle,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_degrees_mode
);

   logic adv;
   logic degrees_mode_ff;
   logic skid_full_ff, rsp_valid_ff, out_take;

   logic                  fr_valid;
   logic [RAD_WIDTH-1:0]  fr_rad;
   qte_ops_type           fr_ops;
   logic                  sq_valid;
   logic [ROOT_WIDTH-1:0] sq_root;
   qte_ops_type           sq_ops;

   logic                          cd_valid;
   logic signed [ANGLE_WIDTH-1:0] yaw_z, pitch_z, roll_z;
   logic                          pipe_valid;
   logic signed [OUT_WIDTH-1:0]   yaw_p, pitch_p, roll_p;

   logic signed [OUT_WIDTH-1:0] yaw_ff, pitch_ff, roll_ff;
   logic signed [OUT_WIDTH-1:0] skid_yaw_ff, skid_pitch_ff, skid_roll_ff;

   assign adv       = !skid_full_ff;
   assign req_stall = skid_full_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         degrees_mode_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         degrees_mode_ff <= csr_degrees_mode;
      end
   end

   qte_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .quat_real (req_quat_real),
      .quat_i    (req_quat_i),
      .quat_j    (req_quat_j),
      .quat_k    (req_quat_k),
      .out_valid (fr_valid),
      .out_rad   (fr_rad),
      .out_ops   (fr_ops)
   );

   qte_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fr_valid),
      .in_rad    (fr_rad),
      .in_ops    (fr_ops),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_ops   (sq_ops)
   );

   qte_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_yaw (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_valid),
      .in_y      (sq_ops.yaw_y),
      .in_x      (sq_ops.yaw_x),
      .out_valid (cd_valid),
      .out_angle (yaw_z)
   );

   qte_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_pitch (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_valid),
      .in_y      (sq_ops.pitch_y),
      .in_x      ($signed({{(OPND_WIDTH-ROOT_WIDTH){1'b0}}, sq_root})),
      .out_valid (),
      .out_angle (pitch_z)
   );

   qte_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_roll (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_valid),
      .in_y      (sq_ops.roll_y),
      .in_x      (sq_ops.roll_x),
      .out_valid (),
      .out_angle (roll_z)
   );

   qte_scale u_scale_yaw (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .degrees_mode (degrees_mode_ff),
      .in_valid     (cd_valid),
      .in_angle     (yaw_z),
      .out_valid    (pipe_valid),
      .out_angle    (yaw_p)
   );

   qte_scale u_scale_pitch (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .degrees_mode (degrees_mode_ff),
      .in_valid     (cd_valid),
      .in_angle     (pitch_z),
      .out_valid    (),
      .out_angle    (pitch_p)
   );

   qte_scale u_scale_roll (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .degrees_mode (degrees_mode_ff),
      .in_valid     (cd_valid),
      .in_angle     (roll_z),
      .out_valid    (),
      .out_angle    (roll_p)
   );

   assign out_take = rsp_valid_ff && !rsp_stall;

   // output register with one skid beat behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (adv && pipe_valid) begin
         if (!rsp_valid_ff || out_take) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_full_ff <= 1'b1;
         end
      end else if (skid_full_ff && out_take) begin
         skid_full_ff <= 1'b0;
         rsp_valid_ff <= 1'b1;
      end else if (out_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && pipe_valid) begin
         if (!rsp_valid_ff || out_take) begin
            yaw_ff   <= yaw_p;
            pitch_ff <= pitch_p;
            roll_ff  <= roll_p;
         end else begin
            skid_yaw_ff   <= yaw_p;
            skid_pitch_ff <= pitch_p;
            skid_roll_ff  <= roll_p;
         end
      end else if (skid_full_ff && out_take) begin
         yaw_ff   <= skid_yaw_ff;
         pitch_ff <= skid_pitch_ff;
         roll_ff  <= skid_roll_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_yaw_angle   = yaw_ff;
   assign rsp_pitch_angle = pitch_ff;
   assign rsp_roll_angle  = roll_ff;

   a_skid_has_out: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> rsp_valid_ff)
      else $error("skid holds a beat while output register is empty");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_full_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid filled without a stalled output");

   a_rsp_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid_ff) |-> $past(!rsp_stall) && !skid_full_ff)
      else $error("output beat dropped without being taken");

endmodule

@@ tb/sv/tb_quaternion_to_euler_angles.sv @@
// Self-checking testbench for quaternion_to_euler_angles: predicts Z-Y-X angles per beat.
// Depends on qte_pkg and the quaternion_to_euler_angles RTL.
module tb_quaternion_to_euler_angles;
   import qte_pkg::*;

   localparam int N_ITER = 16;
   localparam int LATENCY = 5 + 32 + (N_ITER + 1) + 2 + 1;

   typedef struct {
      logic signed [15:0] yaw;
      logic signed [15:0] pitch;
      logic signed [15:0] roll;
   } angles_type;

   function automatic longint asr(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint atan_step(int i);
      longint sum;
      longint term;
      int k;
      int e;
      sum = 0;
      if (i == 0) return 64'd843314857;
      for (k = 0; k < 64; k++) begin
         e = 62 - i * (2 * k + 1);
         if (e < 0) break;
         term = (longint'(1) << e) / (2 * k + 1);
         sum += (k & 1) ? -term : term;
      end
      return asr(sum + (longint'(1) << 31), 32);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint vector_angle(longint y, longint x);
      longint z;
      longint t;
      longint dx;
      longint dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      x *= 1048576;
      y *= 1048576;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = 64'd1686629713;
         end else begin
            t = x; x = -y; y = t; z = -64'd1686629713;
         end
      end
      for (int i = 0; i < N_ITER; i++) begin
         dx = asr(y, i);
         dy = asr(x, i);
         if (y >= 0) begin
            x += dx; y -= dy; z += atan_step(i);
         end else begin
            x -= dx; y += dy; z -= atan_step(i);
         end
      end
      return z;
   endfunction

   function automatic logic signed [15:0] scale_angle(longint z, bit deg);
      longint v;
      if (deg) v = asr(z * 64'd961263669 + (longint'(1) << 47), 48);
      else v = asr(z + (longint'(1) << 16), 17);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function automatic angles_type euler_zyx(logic signed [15:0] q0, logic signed [15:0] q1,
                                            logic signed [15:0] q2, logic signed [15:0] q3,
                                            bit deg);
      longint qr, qi, qj, qk, yy, yx, ry, rx, num, a, b, ma, mb, lim;
      angles_type r;
      qr = q0; qi = q1; qj = q2; qk = q3;
      yy = 2 * (qi * qj + qk * qr);
      yx = qi * qi - qj * qj - qk * qk + qr * qr;
      ry = 2 * (qj * qk + qi * qr);
      rx = -qi * qi - qj * qj + qk * qk + qr * qr;
      num = 2 * (qj * qr - qi * qk);
      a = yx; b = yy;
      lim = longint'(1) << 31;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      if (ma >= lim || mb >= lim || (num < 0 ? -num : num) >= lim) begin
         a = asr(a, 1); b = asr(b, 1); num = asr(num, 1);
      end
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      r.yaw = scale_angle(vector_angle(yy, yx), deg);
      r.pitch = scale_angle(vector_angle(num, longint'(int_sqrt(ma * ma + mb * mb))), deg);
      r.roll = scale_angle(vector_angle(ry, rx), deg);
      return r;
   endfunction

   class angle_board;
      angles_type pending[$];
      bit deg = 1;
      int errors = 0;
      int checked = 0;

      function void note_quat(logic signed [15:0] q0, logic signed [15:0] q1,
                              logic signed [15:0] q2, logic signed [15:0] q3);
         pending.push_back(euler_zyx(q0, q1, q2, q3, deg));
      endfunction

      function void check_angles(logic signed [15:0] y, logic signed [15:0] p,
                                 logic signed [15:0] r);
         angles_type e;
         if (pending.size() == 0) begin
            $error("unexpected result beat");
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (y !== e.yaw) begin
            $error("yaw_angle expected %0d actual %0d", e.yaw, y); errors++;
         end
         if (p !== e.pitch) begin
            $error("pitch_angle expected %0d actual %0d", e.pitch, p); errors++;
         end
         if (r !== e.roll) begin
            $error("roll_angle expected %0d actual %0d", e.roll, r); errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall;
   logic signed [15:0] req_quat_real = 0, req_quat_i = 0, req_quat_j = 0, req_quat_k = 0;
   logic rsp_valid, rsp_stall = 0;
   logic signed [15:0] rsp_yaw_angle, rsp_pitch_angle, rsp_roll_angle;
   logic csr_valid = 0, csr_ready, csr_degrees_mode = 0;

   angle_board board = new();
   int hold_off = 0;
   int items_sent = 0;

   quaternion_to_euler_angles #(.CORDIC_ITERATIONS(N_ITER)) uut (.*);

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_angles(rsp_yaw_angle, rsp_pitch_angle, rsp_roll_angle);
   end

   // receiver stall pattern; long hold-off when requested
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_stall <= 1;
      end else begin
         case ((items_sent / 100) % 3)
            0: rsp_stall <= 0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 1) == 0);
         endcase
      end
   end

   task automatic send_quat(logic signed [15:0] q0, logic signed [15:0] q1,
                            logic signed [15:0] q2, logic signed [15:0] q3);
      req_valid <= 1;
      req_quat_real <= q0; req_quat_i <= q1; req_quat_j <= q2; req_quat_k <= q3;
      do @(posedge clock); while (req_stall);
      board.note_quat(q0, q1, q2, q3);
      items_sent++;
   endtask

   task automatic pause_sender(int n);
      req_valid <= 0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_mode(bit m);
      csr_valid <= 1;
      csr_degrees_mode <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      board.deg = m;
   endtask

   function automatic logic signed [15:0] rand_part();
      case ($urandom_range(0, 9))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'h8000;
         3: return 16'sd0;
         4: return 16'($urandom());
         default: return 16'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   task automatic random_phase(int n);
      int burst;
      while (n > 0) begin
         burst = $urandom_range(1, 30);
         for (int i = 0; i < burst && n > 0; i++, n--)
            send_quat(rand_part(), rand_part(), rand_part(), rand_part());
         if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 8));
      end
   endtask

   initial begin
      logic signed [15:0] d[$];
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: zero, unit axes, extremes, gimbal-lock pitch, out-of-range value
      d = '{0,0,0,0, 16384,0,0,0, -16384,0,0,0, 0,16384,0,0, 0,0,16384,0,
            0,0,0,16384, 11585,0,11585,0, 11585,0,-11585,0, 16384,16384,16384,16384,
            -32768,-32768,-32768,-32768, -32768,32767,-32768,32767,
            32767,32767,32767,32767, 8192,-8192,8192,-8192, 1,0,0,0,
            0,-1,1,0, 16'h5555,16'hAAAA,16'h3333,16'hCCCC};
      for (int m = 1; m >= 0; m--) begin
         if (m == 0) write_mode(0);
         for (int i = 0; i < d.size(); i += 4) send_quat(d[i], d[i+1], d[i+2], d[i+3]);
         drain();
      end
      write_mode(1);
      random_phase(200);
      // hold the receiver off while the sender keeps offering beats
      hold_off <= 200;
      random_phase(150);
      drain();
      write_mode(0);
      random_phase(200);
      drain();
      write_mode(1);
      random_phase(120);
      drain();
      $display("covered %0d quaternions, %0d results checked, both angle units",
               items_sent, board.checked);
      if (board.errors == 0)
         $display("quaternion_to_euler_angles test passed");
      else
         $display("quaternion_to_euler_angles test failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("quaternion_to_euler_angles test failed");
      $finish;
   end
endmodule
